[rtl/core/ssstat_pkg.sv]
package ssstat_pkg;

    // set capacity and sample width
    localparam int MAX_SAMPLES = 256;
    localparam int SAMPLE_BITS = 32;

    // derived widths
    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_BITS + IDX_W;
    localparam int STEP_W = $clog2(SUM_W + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic [CNT_W-1:0]              count_t;

    // per-cycle command to every cell of the sorting chain
    typedef struct packed {
        logic ins;
        logic shift;
        logic clr;
    } cell_ctl_t;

endpackage

[rtl/core/ssstat_cell.sv]
module ssstat_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssstat_pkg::cell_ctl_t ctl,
    input  ssstat_pkg::sample_t   s,
    input  ssstat_pkg::sample_t   prev_val,
    input  logic                  prev_gt,
    input  logic                  prev_occ,
    input  ssstat_pkg::sample_t   next_val,
    output ssstat_pkg::sample_t   val,
    output logic                  gt,
    output logic                  occ
);
    import ssstat_pkg::*;

    sample_t val_reg;
    sample_t val_next;
    logic    occ_reg;
    logic    occ_next;
    logic    place;

    // this cell holds a value strictly above the incoming sample
    assign gt    = occ_reg && (val_reg > s);
    // new sample lands here: first greater cell, or first empty cell
    assign place = !prev_gt && (gt || (prev_occ && !occ_reg));

    // value update: shift toward cell zero, or insert with ripple
    always_comb
    begin
        val_next = val_reg;
        if (ctl.shift)
        begin
            val_next = next_val;
        end
        else if (ctl.ins)
        begin
            if (prev_gt)
            begin
                val_next = prev_val;
            end
            else if (place)
            begin
                val_next = s;
            end
        end
    end

    // occupancy is a thermometer along the chain
    always_comb
    begin
        occ_next = occ_reg;
        if (ctl.clr)
        begin
            occ_next = 1'b0;
        end
        else if (ctl.ins)
        begin
            occ_next = prev_occ;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign val = val_reg;
    assign occ = occ_reg;

endmodule

[rtl/core/ssstat_div.sv]
module ssstat_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ssstat_pkg::sum_t    dividend,
    input  ssstat_pkg::count_t  divisor,
    output logic                busy,
    output ssstat_pkg::sum_t    quotient
);
    import ssstat_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [SUM_W-1:0]  work_reg;
    logic [SUM_W-1:0]  work_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic              neg_reg;
    logic              neg_next;
    logic [SUM_W-1:0]  mag;
    logic [CNT_W:0]    trial;
    logic              fit;

    // magnitude of the dividend, sign restored at the end
    assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

    // one restoring step per cycle
    assign trial = {rem_reg, work_reg[SUM_W-1]};
    assign fit   = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W);
            work_next = mag;
            rem_next  = '0;
            neg_next  = dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[SUM_W-2:0], fit};
            rem_next  = fit ? CNT_W'(trial - {1'b0, dvs_reg}) : CNT_W'(trial);
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? sum_t'(-work_reg) : sum_t'(work_reg);

endmodule

[rtl/core/sample_set_statistics.sv]
// throughput: one sample item per cycle while a set is collected; the finish
//   phase (median shift along the cell chain, 40-step divider) blocks input
// reset: asynchronous, active low; sorting chain empty, running state zero
module sample_set_statistics (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ssstat_pkg::sample_t  sample,
    input  logic                 last_sample,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ssstat_pkg::sample_t  median,
    output ssstat_pkg::sample_t  maximum,
    output ssstat_pkg::sample_t  minimum,
    output ssstat_pkg::sample_t  mean,
    output ssstat_pkg::count_t   sample_count,
    output logic                 overflow
);
    import ssstat_pkg::*;

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_FINISH  = 1'b1;

    logic       state_reg;
    logic       state_next;

    count_t     count_reg;
    count_t     count_next;
    sample_t    min_reg;
    sample_t    min_next;
    sample_t    max_reg;
    sample_t    max_next;
    sum_t       sum_reg;
    sum_t       sum_next;
    logic       drop_reg;
    logic       drop_next;
    logic [IDX_W-1:0] shift_cnt_reg;
    logic [IDX_W-1:0] shift_cnt_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    sample_t    median_reg;
    sample_t    maximum_reg;
    sample_t    minimum_reg;
    sample_t    mean_reg;
    count_t     count_out_reg;
    logic       overflow_reg;

    logic       in_acc;
    logic       room;
    logic       take;
    logic       end_set;
    logic       finish;
    count_t     n_minus1;
    cell_ctl_t  ctl;

    logic       div_busy;
    sum_t       quotient;

    sample_t    cell_val [MAX_SAMPLES];
    logic       cell_gt  [MAX_SAMPLES];
    logic       cell_occ [MAX_SAMPLES];

    logic [SAMPLE_BITS:0] pair_sum;
    sample_t    median_calc;

    // input handshake
    assign in_stall = (state_reg != ST_COLLECT);
    assign in_acc   = in_valid && !in_stall;
    assign room     = count_reg < CNT_W'(MAX_SAMPLES);
    assign take     = in_acc && room;
    assign end_set  = in_acc && last_sample;

    // finish once the median is at the chain head, the quotient is ready
    // and the output register is free
    assign finish = (state_reg == ST_FINISH) && (shift_cnt_reg == '0) && !div_busy
                    && (!out_valid_reg || !out_stall);

    // chain command
    assign ctl.ins   = take;
    assign ctl.shift = (state_reg == ST_FINISH) && (shift_cnt_reg != '0);
    assign ctl.clr   = finish;

    // running min, max, sum, count
    always_comb
    begin
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        drop_next  = drop_reg;
        if (finish)
        begin
            count_next = '0;
            min_next   = '0;
            max_next   = '0;
            sum_next   = '0;
            drop_next  = 1'b0;
        end
        else if (take)
        begin
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + SUM_W'(sample);
            if (count_reg == '0)
            begin
                min_next = sample;
                max_next = sample;
            end
            else
            begin
                if (sample < min_reg)
                begin
                    min_next = sample;
                end
                if (sample > max_reg)
                begin
                    max_next = sample;
                end
            end
        end
        else if (in_acc)
        begin
            drop_next = 1'b1;
        end
    end

    // steps to bring the lower middle sample to cell zero
    assign n_minus1 = count_next - CNT_W'(1);

    always_comb
    begin
        shift_cnt_next = shift_cnt_reg;
        if (end_set)
        begin
            shift_cnt_next = IDX_W'(n_minus1 >> 1);
        end
        else if (ctl.shift)
        begin
            shift_cnt_next = shift_cnt_reg - IDX_W'(1);
        end
    end

    // control state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (end_set)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            count_reg     <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            sum_reg       <= '0;
            drop_reg      <= 1'b0;
            shift_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            drop_reg      <= drop_next;
            shift_cnt_reg <= shift_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sorting chain
    for (genvar i = 0; i < MAX_SAMPLES; i++)
    begin : g_cell
        sample_t prev_val;
        logic    prev_gt;
        logic    prev_occ;
        sample_t next_val;

        if (i == 0)
        begin : g_head
            assign prev_val = '0;
            assign prev_gt  = 1'b0;
            assign prev_occ = 1'b1;
        end
        else
        begin : g_body
            assign prev_val = cell_val[i-1];
            assign prev_gt  = cell_gt[i-1];
            assign prev_occ = cell_occ[i-1];
        end

        if (i == MAX_SAMPLES - 1)
        begin : g_tail
            assign next_val = cell_val[i];
        end
        else
        begin : g_mid
            assign next_val = cell_val[i+1];
        end

        ssstat_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .s        (sample),
            .prev_val (prev_val),
            .prev_gt  (prev_gt),
            .prev_occ (prev_occ),
            .next_val (next_val),
            .val      (cell_val[i]),
            .gt       (cell_gt[i]),
            .occ      (cell_occ[i])
        );
    end

    // mean divider, started with the final sum and count
    ssstat_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (end_set),
        .dividend (sum_next),
        .divisor  (count_next),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // median from the two head cells, even count floors the average
    assign pair_sum    = {cell_val[0][SAMPLE_BITS-1], cell_val[0]}
                       + {cell_val[1][SAMPLE_BITS-1], cell_val[1]};
    assign median_calc = count_reg[0] ? cell_val[0] : sample_t'(pair_sum[SAMPLE_BITS:1]);

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            median_reg    <= median_calc;
            maximum_reg   <= max_reg;
            minimum_reg   <= min_reg;
            mean_reg      <= sample_t'(quotient[SAMPLE_BITS-1:0]);
            count_out_reg <= count_reg;
            overflow_reg  <= drop_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median       = median_reg;
    assign maximum      = maximum_reg;
    assign minimum      = minimum_reg;
    assign mean         = mean_reg;
    assign sample_count = count_out_reg;
    assign overflow     = overflow_reg;

endmodule

[rtl/core/ssstat_chk.sv]
module ssstat_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input ssstat_pkg::sample_t median,
    input ssstat_pkg::sample_t maximum,
    input ssstat_pkg::sample_t minimum,
    input ssstat_pkg::sample_t mean,
    input ssstat_pkg::count_t  sample_count
);
    import ssstat_pkg::*;

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(median) && $stable(mean)
                                   && $stable(sample_count))
        else $error("result changed while stalled");

    // a result always covers at least one stored sample
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_count != '0)
        else $error("result with empty set");

    // median lies within the set range
    a_median: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (minimum <= median) && (median <= maximum))
        else $error("median outside min/max");

    // mean lies within the set range
    a_mean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (minimum <= mean) && (mean <= maximum))
        else $error("mean outside min/max");

endmodule

bind sample_set_statistics ssstat_chk u_ssstat_chk (.*);
